// ===== src/vector_field_grid_engine_unit_macros.svh =====
// Assertion macros shared by the grid engine modules
`ifndef VECTOR_FIELD_GRID_ENGINE_UNIT_MACROS_SVH
`define VECTOR_FIELD_GRID_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define VFGE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid engine check failed");

// next-cycle implication
`define VFGE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid engine check failed");

`endif

// ===== src/vfge_pkg.sv =====
// Types, codes and constants of the vector field grid engine
`timescale 1ns / 1ps
package vfge_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_REPEL  = 2'd1;
  localparam logic [1:0] OP_DECAY  = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [1:0] CFG_NUM_COLS  = 2'd1;
  localparam logic [1:0] CFG_NUM_ROWS  = 2'd2;

  localparam logic [7:0] CELL_SIZE_RST = 8'd10;
  localparam logic [6:0] NUM_COLS_RST  = 7'd64;
  localparam logic [6:0] NUM_ROWS_RST  = 7'd48;

  localparam int DIV_STEPS  = 36;
  localparam int SQRT_STEPS = 20;
  localparam logic [15:0] DECAY_Q16 = 16'd64881;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [15:0]        radius;
    logic signed [15:0] gain;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] force_x;
    logic signed [15:0] force_y;
    logic [12:0]        cells_written;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LKX, ST_LKY_LD, ST_LKY, ST_LK_RD,
    ST_RP_SQ, ST_RP_CHK, ST_SQRT, ST_FDIV_LD, ST_FDIV, ST_MUL1, ST_MUL2,
    ST_DC_RD, ST_DC_WR, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_DIV_STEP, CMD_LKY_LOAD, CMD_LK_READ,
    CMD_SQ, CMD_CHK, CMD_SQRT_STEP, CMD_FDIV_LOAD, CMD_MUL1, CMD_MUL2,
    CMD_DC_READ, CMD_DC_WRITE, CMD_RESULT
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
    logic    adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_reach;
    logic last_cell;
    logic clear_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/vfge_ctrl.sv =====
// Sequencer of the vector field grid engine
`timescale 1ns / 1ps
module vfge_ctrl
  import vfge_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  ctl
);

  state_t state_r, state_nxt;
  logic [5:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = '0;
    ctl.cmd   = CMD_NONE;
    ctl.adv   = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ctl.cmd = CMD_CLEAR;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd = CMD_LOAD;
          case (in_op)
            OP_LOOKUP: state_nxt = ST_LKX;
            OP_REPEL:  state_nxt = ST_RP_SQ;
            OP_DECAY:  state_nxt = ST_DC_RD;
            default:   state_nxt = ST_FIN;
          endcase
        end
      end
      ST_LKX: begin
        ctl.cmd = CMD_DIV_STEP;
        if (step_r == 6'(DIV_STEPS - 1)) state_nxt = ST_LKY_LD;
        else step_nxt = step_r + 6'd1;
      end
      ST_LKY_LD: begin
        ctl.cmd   = CMD_LKY_LOAD;
        state_nxt = ST_LKY;
      end
      ST_LKY: begin
        ctl.cmd = CMD_DIV_STEP;
        if (step_r == 6'(DIV_STEPS - 1)) state_nxt = ST_LK_RD;
        else step_nxt = step_r + 6'd1;
      end
      ST_LK_RD: begin
        ctl.cmd   = CMD_LK_READ;
        state_nxt = ST_FIN;
      end
      ST_RP_SQ: begin
        ctl.cmd   = CMD_SQ;
        state_nxt = ST_RP_CHK;
      end
      ST_RP_CHK: begin
        ctl.cmd = CMD_CHK;
        if (stat.in_reach) begin
          state_nxt = ST_SQRT;
        end else begin
          ctl.adv   = 1'b1;
          state_nxt = stat.last_cell ? ST_FIN : ST_RP_SQ;
        end
      end
      ST_SQRT: begin
        ctl.cmd = CMD_SQRT_STEP;
        if (step_r == 6'(SQRT_STEPS - 1)) state_nxt = ST_FDIV_LD;
        else step_nxt = step_r + 6'd1;
      end
      ST_FDIV_LD: begin
        ctl.cmd   = CMD_FDIV_LOAD;
        state_nxt = ST_FDIV;
      end
      ST_FDIV: begin
        ctl.cmd = CMD_DIV_STEP;
        if (step_r == 6'(DIV_STEPS - 1)) state_nxt = ST_MUL1;
        else step_nxt = step_r + 6'd1;
      end
      ST_MUL1: begin
        ctl.cmd   = CMD_MUL1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        ctl.cmd   = CMD_MUL2;
        ctl.adv   = 1'b1;
        state_nxt = stat.last_cell ? ST_FIN : ST_RP_SQ;
      end
      ST_DC_RD: begin
        ctl.cmd   = CMD_DC_READ;
        state_nxt = ST_DC_WR;
      end
      ST_DC_WR: begin
        ctl.cmd   = CMD_DC_WRITE;
        ctl.adv   = 1'b1;
        state_nxt = stat.last_cell ? ST_FIN : ST_DC_RD;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          ctl.cmd   = CMD_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `include "vector_field_grid_engine_unit_macros.svh"

  `VFGE_ASSERT_NEXT(a_lookup_start, in_valid && in_ready && (in_op == OP_LOOKUP), state_r == ST_LKX)
  `VFGE_ASSERT_NEXT(a_sqrt_done, (state_r == ST_SQRT) && (step_r == 6'(SQRT_STEPS - 1)), state_r == ST_FDIV_LD)
  `VFGE_ASSERT_NOW(a_ready_in_idle, in_ready, state_r == ST_IDLE)

endmodule

// ===== src/vfge_dpath.sv =====
// Datapath of the vector field grid engine: config, grid store and arithmetic
`timescale 1ns / 1ps
module vfge_dpath
  import vfge_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_data,
  input  in_word_t   in_data,
  input  ctrl_cmd_t  ctl,
  output dp_stat_t   stat,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  function automatic logic signed [15:0] sat16(input logic neg, input logic [28:0] mag);
    logic signed [15:0] res;
    if (neg) res = (mag >= 29'd32768) ? -16'sd32768 : 16'(-mag);
    else     res = (mag > 29'd32767) ? 16'sd32767 : 16'(mag);
    return res;
  endfunction

  function automatic logic [15:0] decay16(input logic [15:0] v);
    logic [15:0] a;
    logic [31:0] p;
    logic [15:0] m;
    a = v[15] ? 16'(-v) : v;
    p = a * DECAY_Q16;
    m = p[31:16];
    return v[15] ? 16'(-m) : m;
  endfunction

  logic [7:0]    cs_r;
  logic [6:0]    cols_r, rows_r;
  logic [7:0]    cs_eff;
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;
  logic [11:0]   cs16;

  in_word_t      in_r;
  logic [CW-1:0] c_r;
  logic [RW-1:0] r_r;
  logic [19:0]   xpix_r, ypix_r;
  logic [AW-1:0] addr_r, colbase_r;
  logic [12:0]   cnt_r;
  logic [31:0]   rad2_r;
  logic [19:0]   adx_r, ady_r;
  logic          nx_r, ny_r;
  logic [39:0]   sqx_r, sqy_r;
  logic [39:0]   sq_v_r;
  logic [22:0]   sq_rem_r;
  logic [19:0]   sq_root_r;
  logic [35:0]   dv_num_r;
  logic [19:0]   dv_rem_r, dv_dvs_r;
  logic [11:0]   cq_r;
  logic [32:0]   p1x_r, p1y_r;
  logic [31:0]   rdata_r;
  logic          out_valid_r;
  out_word_t     out_r;

  logic [31:0]   mem [DEPTH];

  always_comb begin
    cs_eff = (cs_r == 8'd0) ? 8'd1 : cs_r;
    if (cols_r == 7'd0) cols_eff = CW'(1);
    else if (int'(cols_r) > MAX_COLS) cols_eff = CW'(MAX_COLS);
    else cols_eff = CW'(cols_r);
    if (rows_r == 7'd0) rows_eff = RW'(1);
    else if (int'(rows_r) > MAX_ROWS) rows_eff = RW'(MAX_ROWS);
    else rows_eff = RW'(rows_r);
  end
  assign cs16 = {cs_eff, 4'b0000};

  logic signed [20:0] sdx, sdy;
  logic [19:0] adx, ady;
  logic [40:0] d2;
  logic        row_last;
  assign sdx = $signed({1'b0, xpix_r}) - $signed({5'b0, in_r.pos_x});
  assign sdy = $signed({1'b0, ypix_r}) - $signed({5'b0, in_r.pos_y});
  assign adx = sdx[20] ? 20'(-sdx) : sdx[19:0];
  assign ady = sdy[20] ? 20'(-sdy) : sdy[19:0];
  assign d2  = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign row_last = (r_r == RW'(rows_eff - 1'b1));

  // divider step
  logic [20:0] dv_t;
  logic        dv_ge;
  assign dv_t  = {dv_rem_r, dv_num_r[35]};
  assign dv_ge = (dv_t >= {1'b0, dv_dvs_r});

  // square root step
  logic [22:0] sq_t, sq_trial;
  logic        sq_ge;
  assign sq_t     = {sq_rem_r[20:0], sq_v_r[39:38]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);

  logic [19:0] rad8;
  assign rad8 = {in_r.radius, 4'b0000};

  logic [15:0] ag;
  logic [48:0] p2x, p2y;
  logic signed [15:0] rfx, rfy;
  assign ag  = in_r.gain[15] ? 16'(-in_r.gain) : in_r.gain;
  assign p2x = p1x_r * ag;
  assign p2y = p1y_r * ag;
  assign rfx = sat16(nx_r ^ in_r.gain[15], p2x[48:20]);
  assign rfy = sat16(ny_r ^ in_r.gain[15], p2y[48:20]);

  logic [CIW-1:0] cidx;
  logic [RIW-1:0] ridx;
  logic [AW-1:0]  lk_addr;
  always_comb begin
    if (cq_r > 12'(cols_eff - 1'b1)) cidx = CIW'(cols_eff - 1'b1);
    else cidx = CIW'(cq_r);
    if (dv_num_r[11:0] > 12'(rows_eff - 1'b1)) ridx = RIW'(rows_eff - 1'b1);
    else ridx = RIW'(dv_num_r[11:0]);
    lk_addr = AW'(int'(cidx) * MAX_ROWS + int'(ridx));
  end

  logic          we;
  logic          re;
  logic [AW-1:0] raddr;
  logic [31:0]   wdata;
  always_comb begin
    we    = 1'b0;
    wdata = '0;
    re    = (ctl.cmd == CMD_LK_READ) || (ctl.cmd == CMD_DC_READ);
    raddr = (ctl.cmd == CMD_LK_READ) ? lk_addr : addr_r;
    case (ctl.cmd)
      CMD_CLEAR:    we = 1'b1;
      CMD_MUL2: begin
        we    = 1'b1;
        wdata = {rfx, rfy};
      end
      CMD_DC_WRITE: begin
        we    = 1'b1;
        wdata = {decay16(rdata_r[31:16]), decay16(rdata_r[15:0])};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr_r] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r        <= CELL_SIZE_RST;
      cols_r      <= NUM_COLS_RST;
      rows_r      <= NUM_ROWS_RST;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      colbase_r   <= '0;
      c_r         <= '0;
      r_r         <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_addr)
          CFG_CELL_SIZE: cs_r   <= cfg_data;
          CFG_NUM_COLS:  cols_r <= cfg_data[6:0];
          CFG_NUM_ROWS:  rows_r <= cfg_data[6:0];
          default:       cs_r   <= cs_r;
        endcase
      end
      if (ctl.cmd == CMD_RESULT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (ctl.cmd == CMD_CLEAR) addr_r <= addr_r + 1'b1;
      if (ctl.cmd == CMD_LOAD) begin
        addr_r    <= '0;
        colbase_r <= '0;
        c_r       <= '0;
        r_r       <= '0;
        cnt_r     <= '0;
      end
      if (ctl.cmd == CMD_MUL2) cnt_r <= cnt_r + 13'd1;
      if (ctl.adv) begin
        if (row_last) begin
          r_r       <= '0;
          c_r       <= c_r + 1'b1;
          colbase_r <= AW'(int'(colbase_r) + MAX_ROWS);
          addr_r    <= AW'(int'(colbase_r) + MAX_ROWS);
        end else begin
          r_r    <= r_r + 1'b1;
          addr_r <= addr_r + 1'b1;
        end
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD: begin
        in_r     <= in_data;
        rad2_r   <= in_data.radius * in_data.radius;
        xpix_r   <= '0;
        ypix_r   <= '0;
        dv_num_r <= {24'b0, in_data.pos_x[15:4]};
        dv_rem_r <= '0;
        dv_dvs_r <= {12'b0, cs_eff};
      end
      CMD_DIV_STEP: begin
        dv_rem_r <= dv_ge ? 20'(dv_t - {1'b0, dv_dvs_r}) : dv_t[19:0];
        dv_num_r <= {dv_num_r[34:0], dv_ge};
      end
      CMD_LKY_LOAD: begin
        cq_r     <= dv_num_r[11:0];
        dv_num_r <= {24'b0, in_r.pos_y[15:4]};
        dv_rem_r <= '0;
      end
      CMD_SQ: begin
        adx_r <= adx;
        ady_r <= ady;
        nx_r  <= sdx[20];
        ny_r  <= sdy[20];
        sqx_r <= adx * adx;
        sqy_r <= ady * ady;
      end
      CMD_CHK: begin
        sq_v_r    <= {d2[31:0], 8'b0};
        sq_rem_r  <= '0;
        sq_root_r <= '0;
      end
      CMD_SQRT_STEP: begin
        sq_rem_r  <= sq_ge ? (sq_t - sq_trial) : sq_t;
        sq_root_r <= {sq_root_r[18:0], sq_ge};
        sq_v_r    <= {sq_v_r[37:0], 2'b00};
      end
      CMD_FDIV_LOAD: begin
        dv_num_r <= {20'(rad8 - sq_root_r), 16'b0};
        dv_rem_r <= '0;
        dv_dvs_r <= rad8;
      end
      CMD_MUL1: begin
        p1x_r <= adx_r[15:0] * dv_num_r[16:0];
        p1y_r <= ady_r[15:0] * dv_num_r[16:0];
      end
      CMD_RESULT: begin
        out_r <= '0;
        case (in_r.op)
          OP_LOOKUP: begin
            out_r.force_x <= rdata_r[31:16];
            out_r.force_y <= rdata_r[15:0];
          end
          OP_REPEL: out_r.cells_written <= cnt_r;
          OP_DECAY: out_r.cells_written <= 13'(int'(cols_eff) * int'(rows_eff));
          default:  out_r.cells_written <= '0;
        endcase
      end
      default: cq_r <= cq_r;
    endcase
    if (ctl.adv) begin
      if (row_last) begin
        ypix_r <= '0;
        xpix_r <= xpix_r + {8'b0, cs16};
      end else begin
        ypix_r <= ypix_r + {8'b0, cs16};
      end
    end
  end

  assign stat.in_reach   = (d2 < {9'b0, rad2_r});
  assign stat.last_cell  = row_last && (c_r == CW'(cols_eff - 1'b1));
  assign stat.clear_last = (addr_r == AW'(DEPTH - 1));
  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

  `include "vector_field_grid_engine_unit_macros.svh"

  `VFGE_ASSERT_NOW(a_result_slot_free, ctl.cmd == CMD_RESULT, !out_valid_r || out_ready)
  `VFGE_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r && $stable(out_r))
  `VFGE_ASSERT_NOW(a_count_bound, out_valid_r, out_r.cells_written <= 13'd4096)

endmodule

// ===== src/vector_field_grid_engine_unit.sv =====
// Top level of the vector field grid engine
// Usage:
//  Input channel in_valid/in_ready/in_data carries one word per operation:
//  lookup, repel or decay. Every word gives exactly one result word on
//  out_valid/out_ready/out_data. Config writes go through cfg_valid/cfg_addr/
//  cfg_data (cfg_ready is always high); index 0 cell size, 1 columns, 2 rows.
//  One operation is in flight at a time; steps from acceptance to result:
//    lookup: x then y on the 1-bit-per-cycle restoring divider, then a read.
//    repel : square and radius check per cell, plus for cells inside it
//            (20 square root steps, 36 divider steps, two multiply stages).
//    decay : memory read then write back per grid cell.
//    unused code: straight to the result.
//  The next word is taken once the previous result sits in the output
//  register. A stalled receiver holds that register and the engine waits
//  before loading a new result.
//  After reset the grid store is zeroed by a clearing pass over all
//  MAX_COLS * MAX_ROWS cells; in_ready stays low until it ends.
`timescale 1ns / 1ps
module vector_field_grid_engine_unit
  import vfge_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_data
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  vfge_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  vfge_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the vector field grid engine: random handshakes and a predictor
`timescale 1ns / 1ps
module tb_top;
  import vfge_pkg::*;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_addr;
  logic [7:0] cfg_data;

  vector_field_grid_engine_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  logic signed [15:0] field_x [GRID_COLS*GRID_ROWS];
  logic signed [15:0] field_y [GRID_COLS*GRID_ROWS];
  logic [7:0] cell_px;
  logic [6:0] cols_q;
  logic [6:0] rows_q;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        in_gap;
  int        out_stall;
  logic      in_taken;
  int        errors;
  int        words_sent;
  int        words_checked;
  int        cells_total;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic int unsigned eff_size();
    return (cell_px == 0) ? 1 : cell_px;
  endfunction

  function automatic int unsigned eff_cols();
    int unsigned c;
    c = (cols_q == 0) ? 1 : cols_q;
    return (c > GRID_COLS) ? GRID_COLS : c;
  endfunction

  function automatic int unsigned eff_rows();
    int unsigned r;
    r = (rows_q == 0) ? 1 : rows_q;
    return (r > GRID_ROWS) ? GRID_ROWS : r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [15:0] saturate(bit neg, longint unsigned mag);
    if (neg) return (mag >= 32768) ? -16'sd32768 : 16'(-mag);
    return (mag > 32767) ? 16'sd32767 : 16'(mag);
  endfunction

  function automatic logic signed [15:0] push_component(longint d, longint unsigned factor,
                                                        int g);
    longint unsigned ad;
    longint unsigned ag;
    ad = (d < 0) ? -d : d;
    ag = (g < 0) ? -g : g;
    return saturate((d < 0) != (g < 0), (ad * factor * ag) >> 20);
  endfunction

  function automatic logic signed [15:0] fade(logic signed [15:0] v);
    longint unsigned a;
    a = (v < 0) ? -longint'(v) : longint'(v);
    return saturate(v < 0, (a * DECAY_Q16) >> 16);
  endfunction

  function automatic out_word_t apply_field_op(in_word_t w);
    out_word_t res;
    int unsigned cs, cols, rows, c, r, idx;
    longint dx, dy;
    longint unsigned d2, rad2, rad8, root_d, factor;
    int g;
    cs = eff_size();
    cols = eff_cols();
    rows = eff_rows();
    res = '0;
    g = w.gain;
    case (w.op)
      OP_LOOKUP: begin
        c = w.pos_x / (cs * 16);
        r = w.pos_y / (cs * 16);
        if (c > cols - 1) c = cols - 1;
        if (r > rows - 1) r = rows - 1;
        res.force_x = field_x[c*GRID_ROWS + r];
        res.force_y = field_y[c*GRID_ROWS + r];
      end
      OP_REPEL: begin
        rad2 = longint'(w.radius) * longint'(w.radius);
        rad8 = longint'(w.radius) << 4;
        for (c = 0; c < cols; c++) begin
          for (r = 0; r < rows; r++) begin
            dx = longint'(c) * cs * 16 - longint'(w.pos_x);
            dy = longint'(r) * cs * 16 - longint'(w.pos_y);
            d2 = dx * dx + dy * dy;
            if (d2 < rad2) begin
              root_d = int_sqrt(d2 << 8);
              factor = ((rad8 - root_d) << 16) / rad8;
              idx = c*GRID_ROWS + r;
              field_x[idx] = push_component(dx, factor, g);
              field_y[idx] = push_component(dy, factor, g);
              res.cells_written = res.cells_written + 1;
            end
          end
        end
      end
      OP_DECAY: begin
        for (c = 0; c < cols; c++) begin
          for (r = 0; r < rows; r++) begin
            idx = c*GRID_ROWS + r;
            field_x[idx] = fade(field_x[idx]);
            field_y[idx] = fade(field_y[idx]);
          end
        end
        res.cells_written = 13'(cols * rows);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, logic [15:0] px, logic [15:0] py,
                                         logic [15:0] rad, logic [15:0] g);
    in_word_t w;
    w.op = op;
    w.pos_x = px;
    w.pos_y = py;
    w.radius = rad;
    w.gain = g;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int p;
    int unsigned span;
    span = eff_size() * 16;
    p = $urandom_range(0, 99);
    w.op = (p < 40) ? OP_LOOKUP : (p < 78) ? OP_REPEL : (p < 92) ? OP_DECAY : OP_SPARE;
    if ($urandom_range(0, 99) < 85) begin
      w.pos_x = 16'($urandom_range(0, span * eff_cols()));
      w.pos_y = 16'($urandom_range(0, span * eff_rows()));
    end else begin
      w.pos_x = 16'($urandom);
      w.pos_y = 16'($urandom);
    end
    p = $urandom_range(0, 99);
    if (p < 80) w.radius = 16'($urandom_range(0, span * 3));
    else if (p < 95 || eff_cols() * eff_rows() > 64) w.radius = 16'($urandom_range(0, span * 6));
    else w.radius = 16'($urandom);
    w.gain = 16'($urandom);
    return w;
  endfunction

  task automatic queue_word(in_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_words.size() != 0 || expected_words.size() != 0 || in_valid)
      @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic grid_setting(logic [7:0] cs, logic [7:0] cols, logic [7:0] rows);
    drain();
    write_reg(CFG_CELL_SIZE, cs);
    write_reg(CFG_NUM_COLS, cols);
    write_reg(CFG_NUM_ROWS, rows);
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) queue_word(random_word());
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_CELL_SIZE: cell_px <= cfg_data;
          CFG_NUM_COLS:  cols_q <= cfg_data[6:0];
          CFG_NUM_ROWS:  rows_q <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_words.insert(expected_words.size(), apply_field_op(in_data));
        words_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, out_data);
          errors++;
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          words_checked++;
          cells_total += out_data.cells_written;
          if (out_data.force_x !== e.force_x) begin
            $display("%0t: force_x expected %0d got %0d", $time, e.force_x, out_data.force_x);
            errors++;
          end
          if (out_data.force_y !== e.force_y) begin
            $display("%0t: force_y expected %0d got %0d", $time, e.force_y, out_data.force_y);
            errors++;
          end
          if (out_data.cells_written !== e.cells_written) begin
            $display("%0t: cells_written expected %0d got %0d", $time, e.cells_written,
                     out_data.cells_written);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_words.size() != 0) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall <= pick_gap();
      end
    end
  end

  initial begin
    #20000000;
    $display("vector_field_grid_engine_unit test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = CFG_CELL_SIZE;
    cfg_data = '0;
    in_gap = 0;
    out_stall = 0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    cells_total = 0;
    cell_px = CELL_SIZE_RST;
    cols_q = NUM_COLS_RST;
    rows_q = NUM_ROWS_RST;
    foreach (field_x[i]) begin
      field_x[i] = '0;
      field_y[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_word(make_word(OP_LOOKUP, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_word(make_word(OP_REPEL, 16'd320, 16'd320, 16'd400, 16'h0100));
    queue_word(make_word(OP_LOOKUP, 16'd480, 16'd320, 16'd0, 16'd0));
    queue_word(make_word(OP_LOOKUP, 16'd160, 16'd479, 16'd0, 16'd0));
    queue_word(make_word(OP_REPEL, 16'd500, 16'd500, 16'd0, 16'h7fff));
    queue_word(make_word(OP_LOOKUP, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    queue_word(make_word(OP_REPEL, 16'd0, 16'd0, 16'hffff, 16'h8000));
    queue_word(make_word(OP_LOOKUP, 16'hffff, 16'hffff, 16'd0, 16'd0));
    queue_word(make_word(OP_LOOKUP, 16'd800, 16'd0, 16'd0, 16'd0));
    queue_word(make_word(OP_REPEL, 16'hffff, 16'hffff, 16'd2000, 16'h7fff));
    queue_word(make_word(OP_DECAY, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_word(make_word(OP_LOOKUP, 16'hfff0, 16'd7000, 16'd0, 16'd0));
    queue_word(make_word(OP_SPARE, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    queue_word(make_word(OP_REPEL, 16'd480, 16'd470, 16'd161, 16'hffff));
    queue_word(make_word(OP_LOOKUP, 16'd480, 16'd470, 16'd0, 16'd0));
    queue_word(make_word(OP_DECAY, 16'd0, 16'd0, 16'd0, 16'd0));

    grid_setting(8'd1, 8'd64, 8'd64);
    queue_word(make_word(OP_REPEL, 16'd500, 16'd500, 16'd40, 16'h0400));
    queue_word(make_word(OP_LOOKUP, 16'd512, 16'd496, 16'd0, 16'd0));
    queue_word(make_word(OP_LOOKUP, 16'hffff, 16'hffff, 16'd0, 16'd0));
    queue_word(make_word(OP_DECAY, 16'd0, 16'd0, 16'd0, 16'd0));

    grid_setting(8'd255, 8'd1, 8'd1);
    queue_word(make_word(OP_LOOKUP, 16'hffff, 16'hffff, 16'd0, 16'd0));
    random_words(20);

    grid_setting(8'd4, 8'd8, 8'd8);
    random_words(45);

    grid_setting(8'd0, 8'd0, 8'd100);
    random_words(25);

    grid_setting(8'd16, 8'd12, 8'd5);
    random_words(30);

    drain();
    repeat (20) @(negedge clk);
    $display("Checked %0d results of %0d words over six grid settings,", words_checked,
             words_sent);
    $display("including %0d cell updates from repel and decay.", cells_total);
    if (errors == 0) begin
      $display("vector_field_grid_engine_unit test passed");
    end else begin
      $display("vector_field_grid_engine_unit test failed");
    end
    $finish;
  end

endmodule
